FILE: hdl/rgb_to_yuv_packer_unit_macros.svh
// assertion helpers used by the top rtl file
`ifndef RGB_TO_YUV_PACKER_UNIT_MACROS_SVH
`define RGB_TO_YUV_PACKER_UNIT_MACROS_SVH

// property checked at every clock edge out of reset
`define R2Y_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define R2Y_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/r2y_pkg.sv
package r2y_pkg;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 16;
  localparam int OUT_W  = 16;
  localparam int COL_W  = 11;
  localparam int PPR_W  = 12;
  localparam int CFG_W  = 12;
  localparam int IDX_W  = 1;

  localparam int MAX_PAIRS_PER_ROW_DEF = 2048;
  localparam logic [PPR_W-1:0] PPR_RESET = 12'd960;

  // bt.601 studio-range coefficients, magnitudes
  localparam logic [SUM_W-1:0] C_YR  = 16'd66;
  localparam logic [SUM_W-1:0] C_YG  = 16'd129;
  localparam logic [SUM_W-1:0] C_YB  = 16'd25;
  localparam logic [SUM_W-1:0] C_UR  = 16'd38;
  localparam logic [SUM_W-1:0] C_UG  = 16'd74;
  localparam logic [SUM_W-1:0] C_UB  = 16'd112;
  localparam logic [SUM_W-1:0] C_VR  = 16'd112;
  localparam logic [SUM_W-1:0] C_VG  = 16'd94;
  localparam logic [SUM_W-1:0] C_VB  = 16'd18;
  // rounding 128 plus offset (16 or 128) already scaled by 256
  localparam logic [SUM_W-1:0] Y_BIAS = 16'd4224;
  localparam logic [SUM_W-1:0] C_BIAS = 16'd32896;
  localparam logic [OUT_W-1:0] P010_MASK = 16'hFFC0;

  typedef enum logic [1:0] {
    FMT_UYVY,
    FMT_NV12,
    FMT_NV21,
    FMT_P010
  } fmt_t;

  typedef enum logic [IDX_W-1:0] {
    REG_OUTPUT_FORMAT,
    REG_PAIRS_PER_ROW
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] cb;
    logic [SUM_W-1:0] cr;
  } pix_sums_t;

  typedef struct packed {
    fmt_t fmt;
    logic odd_row;
  } merge_ctl_t;

  function automatic logic [OUT_W-1:0] finish(input logic [SUM_W-1:0] sum,
                                              input logic ten_bit);
    logic [OUT_W-1:0] res;
    if (ten_bit) begin
      res = sum & P010_MASK;
    end else begin
      res = {8'd0, sum[SUM_W-1:8]};
    end
    return res;
  endfunction

endpackage

FILE: hdl/rgb_to_yuv_packer_unit.sv
// channel  direction  handshake                      payload
// in_      input      in_valid / in_stall            two rgb888 pixels (left, right)
// out_     output     out_valid / out_stall          two luma, two chroma, chroma_valid
// cfg_     input      cfg_valid / cfg_ready          cfg_index, cfg_data
//
// a pair passes the lane sums, then the output register; one pair per clock unless out_stall holds it
// the rate is set by the two-stage pipe: lane sum registers, then the merge output register
// rst_n (synchronous) clears valid bits, row position and config registers
// a stalled output holds its pair while one more pair waits in the lane stage
// in_stall rises only when both stages hold a pair and out_stall is high
// cfg_ready is always high
module rgb_to_yuv_packer_unit #(
  parameter int MAX_PAIRS_PER_ROW = r2y_pkg::MAX_PAIRS_PER_ROW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // pixel pair in
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [r2y_pkg::PIX_W-1:0]   in_red_left,
  input  logic [r2y_pkg::PIX_W-1:0]   in_green_left,
  input  logic [r2y_pkg::PIX_W-1:0]   in_blue_left,
  input  logic [r2y_pkg::PIX_W-1:0]   in_red_right,
  input  logic [r2y_pkg::PIX_W-1:0]   in_green_right,
  input  logic [r2y_pkg::PIX_W-1:0]   in_blue_right,
  // packed result out
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [r2y_pkg::OUT_W-1:0]   out_luma_left,
  output logic [r2y_pkg::OUT_W-1:0]   out_luma_right,
  output logic [r2y_pkg::OUT_W-1:0]   out_chroma_first,
  output logic [r2y_pkg::OUT_W-1:0]   out_chroma_second,
  output logic                        out_chroma_valid,
  // register writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [r2y_pkg::IDX_W-1:0]   cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0]   cfg_data
);
  import r2y_pkg::*;

`include "rgb_to_yuv_packer_unit_macros.svh"

  // config registers
  fmt_t             fmt_r, fmt_nxt;
  logic [PPR_W-1:0] ppr_r, ppr_nxt;

  // pipeline control
  logic       s1_valid_r, s1_valid_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       s1_en, s2_en;
  logic       in_xfer;
  logic       odd_row;
  merge_ctl_t s1_ctl_r;
  pix_sums_t  sums_left, sums_right;

  assign cfg_ready = 1'b1;

  always_comb begin
    fmt_nxt = fmt_r;
    ppr_nxt = ppr_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OUTPUT_FORMAT: fmt_nxt = fmt_t'(cfg_data[1:0]);
        REG_PAIRS_PER_ROW: ppr_nxt = cfg_data[PPR_W-1:0];
        default: begin
          fmt_nxt = fmt_r;
          ppr_nxt = ppr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_UYVY;
      ppr_r <= PPR_RESET;
    end else begin
      fmt_r <= fmt_nxt;
      ppr_r <= ppr_nxt;
    end
  end

  // output register advances when empty or its pair is taken;
  // lane stage advances when empty or it can move forward
  assign s2_en    = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_stall = !s1_en;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = s1_en ? in_valid : s1_valid_r;
    out_valid_nxt = s2_en ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // row parity and format travel with the pair
  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_ctl_r.fmt     <= fmt_r;
      s1_ctl_r.odd_row <= odd_row;
    end
  end

  r2y_row_ctr #(
    .MAX_PAIRS_PER_ROW(MAX_PAIRS_PER_ROW)
  ) u_row_ctr (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_xfer),
    .pairs_per_row(ppr_r),
    .odd_row      (odd_row)
  );

  r2y_lane u_lane_left (
    .clk  (clk),
    .en   (s1_en),
    .red  (in_red_left),
    .green(in_green_left),
    .blue (in_blue_left),
    .sums (sums_left)
  );

  r2y_lane u_lane_right (
    .clk  (clk),
    .en   (s1_en),
    .red  (in_red_right),
    .green(in_green_right),
    .blue (in_blue_right),
    .sums (sums_right)
  );

  r2y_merge u_merge (
    .clk          (clk),
    .en           (s2_en),
    .left         (sums_left),
    .right        (sums_right),
    .ctl          (s1_ctl_r),
    .luma_left    (out_luma_left),
    .luma_right   (out_luma_right),
    .chroma_first (out_chroma_first),
    .chroma_second(out_chroma_second),
    .chroma_valid (out_chroma_valid)
  );

  assign out_valid = out_valid_r;

  // chroma words are cleared whenever they are not to be stored
  `R2Y_ASSERT(a_chroma_zero, (out_valid && !out_chroma_valid) |-> (out_chroma_first == '0 && out_chroma_second == '0), "chroma not cleared on skipped pair")
  // a pair waiting in the lane stage is not dropped while the output is held
  `R2Y_ASSERT_NEXT(a_s1_hold, (s1_valid_r && !s2_en), s1_valid_r, "lane stage lost a pair")
  // input is held off only when both stages are full
  `R2Y_ASSERT(a_stall_full, in_stall |-> (s1_valid_r && out_valid_r && out_stall), "input stalled with room in pipe")

endmodule

FILE: hdl/r2y_lane.sv
module r2y_lane (
  input  logic                        clk,
  input  logic                        en,
  input  logic [r2y_pkg::PIX_W-1:0]   red,
  input  logic [r2y_pkg::PIX_W-1:0]   green,
  input  logic [r2y_pkg::PIX_W-1:0]   blue,
  output r2y_pkg::pix_sums_t          sums
);
  import r2y_pkg::*;

  logic [SUM_W-1:0] r_x, g_x, b_x;
  pix_sums_t sums_nxt, sums_r;

  assign r_x = SUM_W'(red);
  assign g_x = SUM_W'(green);
  assign b_x = SUM_W'(blue);

  // all sums stay in 0..65535, so modulo-2^16 arithmetic is exact
  always_comb begin
    sums_nxt.y  = C_YR * r_x + C_YG * g_x + C_YB * b_x + Y_BIAS;
    sums_nxt.cb = C_UB * b_x + C_BIAS - C_UR * r_x - C_UG * g_x;
    sums_nxt.cr = C_VR * r_x + C_BIAS - C_VG * g_x - C_VB * b_x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sums_r <= sums_nxt;
    end
  end

  assign sums = sums_r;

endmodule

FILE: hdl/r2y_row_ctr.sv
module r2y_row_ctr #(
  parameter int MAX_PAIRS_PER_ROW = r2y_pkg::MAX_PAIRS_PER_ROW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  logic [r2y_pkg::PPR_W-1:0]   pairs_per_row,
  output logic                        odd_row
);
  import r2y_pkg::*;

  localparam int MAX_W = $clog2(MAX_PAIRS_PER_ROW + 1);
  localparam int LEN_W = (MAX_W > PPR_W) ? MAX_W : PPR_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAIRS_PER_ROW);

  logic [COL_W-1:0] col_r, col_nxt, col_inc;
  logic             odd_r, odd_nxt;
  logic [LEN_W-1:0] len_raw, row_len;
  logic             row_end;

  always_comb begin
    len_raw = LEN_W'(pairs_per_row);
    if (len_raw == '0) begin
      row_len = LEN_W'(1);
    end else if (len_raw > MAX_LEN) begin
      row_len = MAX_LEN;
    end else begin
      row_len = len_raw;
    end
    col_inc = col_r + COL_W'(1);
    // a count already past a shortened row ends the row too
    row_end = (col_inc == '0) || ({{(LEN_W-COL_W){1'b0}}, col_inc} >= row_len);
    col_nxt = col_r;
    odd_nxt = odd_r;
    if (advance) begin
      col_nxt = row_end ? '0 : col_inc;
      odd_nxt = row_end ? ~odd_r : odd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      odd_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      odd_r <= odd_nxt;
    end
  end

  assign odd_row = odd_r;

endmodule

FILE: hdl/r2y_merge.sv
module r2y_merge (
  input  logic                        clk,
  input  logic                        en,
  input  r2y_pkg::pix_sums_t          left,
  input  r2y_pkg::pix_sums_t          right,
  input  r2y_pkg::merge_ctl_t         ctl,
  output logic [r2y_pkg::OUT_W-1:0]   luma_left,
  output logic [r2y_pkg::OUT_W-1:0]   luma_right,
  output logic [r2y_pkg::OUT_W-1:0]   chroma_first,
  output logic [r2y_pkg::OUT_W-1:0]   chroma_second,
  output logic                        chroma_valid
);
  import r2y_pkg::*;

  logic             ten;
  logic [OUT_W-1:0] u, v;
  logic [OUT_W-1:0] yl_nxt, yr_nxt, c1_nxt, c2_nxt;
  logic             cv_nxt;
  logic [OUT_W-1:0] yl_r, yr_r, c1_r, c2_r;
  logic             cv_r;

  always_comb begin
    ten    = (ctl.fmt == FMT_P010);
    yl_nxt = finish(left.y, ten);
    yr_nxt = finish(right.y, ten);
    // packed 4:2:2 takes chroma from the left pixel on every pair,
    // the 4:2:0 formats from the bottom-right pixel of each 2x2 block
    if (ctl.fmt == FMT_UYVY) begin
      u      = finish(left.cb, 1'b0);
      v      = finish(left.cr, 1'b0);
      cv_nxt = 1'b1;
    end else begin
      u      = finish(right.cb, ten);
      v      = finish(right.cr, ten);
      cv_nxt = ctl.odd_row;
    end
    c1_nxt = '0;
    c2_nxt = '0;
    if (cv_nxt) begin
      if (ctl.fmt == FMT_NV21) begin
        c1_nxt = v;
        c2_nxt = u;
      end else begin
        c1_nxt = u;
        c2_nxt = v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yl_r <= yl_nxt;
      yr_r <= yr_nxt;
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
      cv_r <= cv_nxt;
    end
  end

  assign luma_left     = yl_r;
  assign luma_right    = yr_r;
  assign chroma_first  = c1_r;
  assign chroma_second = c2_r;
  assign chroma_valid  = cv_r;

endmodule

FILE: test/yuv_pair_checker.sv
module yuv_pair_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [r2y_pkg::PIX_W-1:0] in_red_left,
  input  logic [r2y_pkg::PIX_W-1:0] in_green_left,
  input  logic [r2y_pkg::PIX_W-1:0] in_blue_left,
  input  logic [r2y_pkg::PIX_W-1:0] in_red_right,
  input  logic [r2y_pkg::PIX_W-1:0] in_green_right,
  input  logic [r2y_pkg::PIX_W-1:0] in_blue_right,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [r2y_pkg::OUT_W-1:0] out_luma_left,
  input  logic [r2y_pkg::OUT_W-1:0] out_luma_right,
  input  logic [r2y_pkg::OUT_W-1:0] out_chroma_first,
  input  logic [r2y_pkg::OUT_W-1:0] out_chroma_second,
  input  logic                      out_chroma_valid,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [r2y_pkg::IDX_W-1:0] cfg_index,
  input  logic [r2y_pkg::CFG_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);
  import r2y_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int ROW_MAX = MAX_PAIRS_PER_ROW_DEF;

  typedef struct packed {
    logic [OUT_W-1:0] luma_left;
    logic [OUT_W-1:0] luma_right;
    logic [OUT_W-1:0] chroma_first;
    logic [OUT_W-1:0] chroma_second;
    logic             chroma_valid;
  } yuv_pair_t;

  yuv_pair_t        expected_pairs[$];
  fmt_t             fmt_shadow;
  logic [PPR_W-1:0] row_len_shadow;
  logic [COL_W-1:0] column;
  logic             odd_row;
  int               results_seen;

  // full-precision sums with rounding and offset folded in
  function automatic int unsigned luma_sum(input int unsigned r, g, b);
    return 66 * r + 129 * g + 25 * b + 128 + 4096;
  endfunction

  function automatic int unsigned cb_sum(input int unsigned r, g, b);
    return 112 * b + 128 + 32768 - 38 * r - 74 * g;
  endfunction

  function automatic int unsigned cr_sum(input int unsigned r, g, b);
    return 112 * r + 128 + 32768 - 94 * g - 18 * b;
  endfunction

  function automatic logic [OUT_W-1:0] scale_sum(input logic [31:0] sum, input logic ten_bit);
    if (ten_bit) return sum[15:0] & P010_MASK;
    return sum[23:8];
  endfunction

  function automatic yuv_pair_t convert_pair(input fmt_t fmt, input logic odd,
                                             input int unsigned rl, gl, bl, rr, gr, br);
    yuv_pair_t        p;
    logic             ten_bit;
    logic [OUT_W-1:0] cb;
    logic [OUT_W-1:0] cr;
    ten_bit = (fmt == FMT_P010);
    p.luma_left  = scale_sum(luma_sum(rl, gl, bl), ten_bit);
    p.luma_right = scale_sum(luma_sum(rr, gr, br), ten_bit);
    if (fmt == FMT_UYVY) begin
      cb = scale_sum(cb_sum(rl, gl, bl), 1'b0);
      cr = scale_sum(cr_sum(rl, gl, bl), 1'b0);
      p.chroma_valid = 1'b1;
    end else begin
      cb = scale_sum(cb_sum(rr, gr, br), ten_bit);
      cr = scale_sum(cr_sum(rr, gr, br), ten_bit);
      p.chroma_valid = odd;
    end
    p.chroma_first  = '0;
    p.chroma_second = '0;
    if (p.chroma_valid) begin
      if (fmt == FMT_NV21) begin
        p.chroma_first  = cr;
        p.chroma_second = cb;
      end else begin
        p.chroma_first  = cb;
        p.chroma_second = cr;
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    yuv_pair_t got;
    yuv_pair_t want;
    int        eff_len;
    if (!rst_n) begin
      expected_pairs.delete();
      fmt_shadow     = FMT_UYVY;
      row_len_shadow = PPR_RESET;
      column         = '0;
      odd_row        = 1'b0;
      mismatches     = 0;
      results_seen   = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_luma_left, out_luma_right, out_chroma_first, out_chroma_second,
               out_chroma_valid};
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("chk: result %0d with nothing expected: y %h %h c %h %h v %b",
                     results_seen, got.luma_left, got.luma_right, got.chroma_first,
                     got.chroma_second, got.chroma_valid);
        end else begin
          want = expected_pairs.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("chk: result %0d exp y %h %h c %h %h v %b, got y %h %h c %h %h v %b",
                       results_seen, want.luma_left, want.luma_right, want.chroma_first,
                       want.chroma_second, want.chroma_valid, got.luma_left,
                       got.luma_right, got.chroma_first, got.chroma_second,
                       got.chroma_valid);
          end
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OUTPUT_FORMAT: fmt_shadow = fmt_t'(cfg_data[1:0]);
          REG_PAIRS_PER_ROW: row_len_shadow = cfg_data[PPR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_pairs.push_back(convert_pair(fmt_shadow, odd_row, in_red_left,
                                              in_green_left, in_blue_left, in_red_right,
                                              in_green_right, in_blue_right));
        eff_len = (row_len_shadow == 0) ? 1 :
                  (row_len_shadow > ROW_MAX) ? ROW_MAX : int'(row_len_shadow);
        column = column + 1'b1;
        if (column == 0 || column >= eff_len) begin
          column  = '0;
          odd_row = ~odd_row;
        end
      end
    end
    outstanding = expected_pairs.size();
  end

endmodule

FILE: test/tb.sv
module tb;
  import r2y_pkg::*;

  localparam int RANDOM_ITEMS   = 760;
  localparam int LONG_ROW_ITEMS = 100;  // closing run at a clamped row length
  localparam int LONG_HOLD      = 48;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;

  // one pixel pair as it goes on the input ports
  typedef struct packed {
    logic [PIX_W-1:0] rl;
    logic [PIX_W-1:0] gl;
    logic [PIX_W-1:0] bl;
    logic [PIX_W-1:0] rr;
    logic [PIX_W-1:0] gr;
    logic [PIX_W-1:0] br;
  } rgb_pair_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_red_left = '0;
  logic [PIX_W-1:0] in_green_left = '0;
  logic [PIX_W-1:0] in_blue_left = '0;
  logic [PIX_W-1:0] in_red_right = '0;
  logic [PIX_W-1:0] in_green_right = '0;
  logic [PIX_W-1:0] in_blue_right = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OUT_W-1:0] out_luma_left;
  logic [OUT_W-1:0] out_luma_right;
  logic [OUT_W-1:0] out_chroma_first;
  logic [OUT_W-1:0] out_chroma_second;
  logic             out_chroma_valid;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;

  // idling switches per phase, and the long receiver hold-off request
  bit   tx_idling = 1'b0;
  bit   rx_idling = 1'b0;
  int   holds_wanted = 0;
  int   holds_served = 0;
  fmt_t fmt_now = FMT_UYVY;
  int   pairs_by_fmt[4] = '{0, 0, 0, 0};
  int   reg_writes = 0;
  int   stall_cycles = 0;
  int   idle_cycles = 0;

  rgb_to_yuv_packer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red_left       (in_red_left),
    .in_green_left     (in_green_left),
    .in_blue_left      (in_blue_left),
    .in_red_right      (in_red_right),
    .in_green_right    (in_green_right),
    .in_blue_right     (in_blue_right),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_luma_left     (out_luma_left),
    .out_luma_right    (out_luma_right),
    .out_chroma_first  (out_chroma_first),
    .out_chroma_second (out_chroma_second),
    .out_chroma_valid  (out_chroma_valid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // predicts every transfer and compares, hands back its error count
  yuv_pair_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red_left       (in_red_left),
    .in_green_left     (in_green_left),
    .in_blue_left      (in_blue_left),
    .in_red_right      (in_red_right),
    .in_green_right    (in_green_right),
    .in_blue_right     (in_blue_right),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_luma_left     (out_luma_left),
    .out_luma_right    (out_luma_right),
    .out_chroma_first  (out_chroma_first),
    .out_chroma_second (out_chroma_second),
    .out_chroma_valid  (out_chroma_valid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // color level with extra weight on black and full scale
  function automatic logic [PIX_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rgb_pair_t rand_pair();
    rgb_pair_t p;
    p.rl = rand_level();
    p.gl = rand_level();
    p.bl = rand_level();
    p.rr = rand_level();
    p.gr = rand_level();
    p.br = rand_level();
    return p;
  endfunction

  // row lengths: mostly short rows so chroma rows come often, plus the clamp cases
  function automatic logic [CFG_W-1:0] pick_row_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(2048);
      3: return '1;
      default: return CFG_W'($urandom_range(2, 17));
    endcase
  endfunction

  // one input transfer, with an optional gap before it
  task automatic send_pair(input rgb_pair_t p);
    int gap;
    gap = tx_idling ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_red_left    <= p.rl;
    in_green_left  <= p.gl;
    in_blue_left   <= p.bl;
    in_red_right   <= p.rr;
    in_green_right <= p.gr;
    in_blue_right  <= p.br;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_by_fmt[fmt_now]++;
  endtask

  // stop offering and wait until every expected result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // pipe is two deep, give it a little extra
    repeat (4) @(posedge clk);
  endtask

  // both registers written back to back while the block is idle
  task automatic set_config(input fmt_t fmt, input logic [CFG_W-1:0] row_pairs);
    logic [CFG_W-1:0] fmt_word;
    wait_drained();
    // upper bits of the format word are don't-care, so toggle them too
    fmt_word = CFG_W'($urandom());
    fmt_word[1:0] = fmt;
    cfg_valid <= 1'b1;
    cfg_index <= REG_OUTPUT_FORMAT;
    cfg_data  <= fmt_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_PAIRS_PER_ROW;
    cfg_data  <= row_pairs;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fmt_now = fmt;
    reg_writes += 2;
  endtask

  // receiver: random stall runs, plus one long hold-off on request
  initial begin : receiver
    int run;
    forever begin
      @(posedge clk);
      if (holds_served != holds_wanted) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        run = gap_len();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog: ends the run if no transfer happens on any channel for too long
  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (in_valid && in_stall) stall_cycles++;
    end
    $display("tb: watchdog, no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    rgb_pair_t        corners[12];
    logic [CFG_W-1:0] row_pairs;
    fmt_t             fmt;
    int               phase_items;
    int               sent;
    int               phase;

    // black, white, primaries, checkerboard bits, extreme chroma corners
    corners = '{48'h000000_000000, 48'hFFFFFF_FFFFFF, 48'hFFFFFF_000000,
                48'h000000_FFFFFF, 48'hFF0000_00FF00, 48'h0000FF_FFFF00,
                48'hAAAAAA_555555, 48'h55AA55_AA55AA, 48'h00FFFF_FF00FF,
                48'hFFFF00_0000FF, 48'h0180FE_7F8081, 48'h010101_FEFEFE};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners at reset settings: uyvy, chroma on every pair
    for (int i = 0; i < 8; i++) send_pair(corners[i]);

    // every format with one-pair rows so 4:2:0 chroma alternates valid and dropped;
    // p010 gets a zero row length, which must act as one
    for (int f = 0; f < 4; f++) begin
      set_config(fmt_t'(f), (f == 3) ? CFG_W'(0) : CFG_W'(1));
      for (int i = 0; i < 4; i++) send_pair(corners[(f * 4 + i + 4) % 12]);
    end

    // random phases; row position carries over each config change
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      fmt = (phase < 4) ? fmt_t'(phase) : fmt_t'($urandom_range(0, 3));
      row_pairs = pick_row_len();
      set_config(fmt, row_pairs);
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      phase_items = $urandom_range(30, 90);
      if (phase == 2) begin
        // back-pressure: sender keeps offering while the receiver holds off
        tx_idling = 1'b0;
        phase_items = 90;
      end
      for (int i = 0; i < phase_items; i++) begin
        if (phase == 2 && i == 5) holds_wanted++;
        if (phase == 3 && i == phase_items / 2) wait_drained();
        send_pair(rand_pair());
      end
      sent += phase_items;
      phase++;
    end

    // closing run with the row length above the maximum
    set_config(FMT_NV21, '1);
    tx_idling = 1'b1;
    rx_idling = 1'b1;
    for (int i = 0; i < LONG_ROW_ITEMS; i++) send_pair(rand_pair());

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: pairs per format uyvy %0d, nv12 %0d, nv21 %0d, p010 %0d",
             pairs_by_fmt[FMT_UYVY], pairs_by_fmt[FMT_NV12], pairs_by_fmt[FMT_NV21],
             pairs_by_fmt[FMT_P010]);
    $display("tb: %0d register writes, rows of 0 to 4095 pairs, %0d cycles of input stall",
             reg_writes, stall_cycles);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
